FILE: rtl/mavw_pkg.sv
// ----------------------------------------------------------------------------
// mavw_pkg
// Shared types and constants of the moving average with warm-up.
// ----------------------------------------------------------------------------
package mavw_pkg;

  localparam int WLEN_BITS = 5;
  localparam logic [WLEN_BITS-1:0] WLEN_RESET = 5'd10;

  typedef enum logic {
    OP_SAMPLE,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

FILE: rtl/moving_average_warmup.sv
// ----------------------------------------------------------------------------
// moving_average_warmup
// Sliding-window mean of signed samples with warm-up over a partial window.
// ----------------------------------------------------------------------------
// Each sample passes through the update state, the restoring divider, which
// produces one quotient bit per cycle, and the output state; a clear beat
// goes straight to the output state. An input register and a two-entry queue
// sit in front of the datapath and a result register behind it, so input
// beats are taken while a mean waits at the output. No clearing pass after
// reset: ring entries are only read once the fill count shows they were
// written. A window_len write also empties the window.
module moving_average_warmup #(
  parameter int MAX_WINDOW  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mavw_pkg::WLEN_BITS-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_BITS-1:0]  sample,
  input  logic                           clear,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_BITS-1:0]  mean
);
  import mavw_pkg::*;

  localparam int QW = SAMPLE_BITS + 1;

  logic                          push_valid;
  logic                          push_ready;
  op_t                           push_op;
  logic signed [SAMPLE_BITS-1:0] push_sample;
  logic                          q_valid;
  logic                          q_ready;
  logic [QW-1:0]                 q_data;
  op_t                           q_op;
  logic signed [SAMPLE_BITS-1:0] q_sample;

  mavw_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .clear       (clear),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_op     (push_op),
    .push_sample (push_sample)
  );

  mavw_fifo #(
    .WIDTH(QW),
    .DEPTH(2)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_op, push_sample}),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  assign q_op     = op_t'(q_data[QW-1]);
  assign q_sample = q_data[SAMPLE_BITS-1:0];

  mavw_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_op      (q_op),
    .q_sample  (q_sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mean      (mean)
  );

endmodule

FILE: rtl/mavw_front.sv
// ----------------------------------------------------------------------------
// mavw_front
// Input stage: takes input beats, tags each one as a sample or a clear and
// holds it in a register until the queue takes it.
// ----------------------------------------------------------------------------
module mavw_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          clear,
  output logic                          push_valid,
  input  logic                          push_ready,
  output mavw_pkg::op_t                 push_op,
  output logic signed [SAMPLE_BITS-1:0] push_sample
);
  import mavw_pkg::*;

  logic                          hold_valid;
  op_t                           hold_op;
  logic signed [SAMPLE_BITS-1:0] hold_sample;

  assign in_ready    = !hold_valid || push_ready;
  assign push_valid  = hold_valid;
  assign push_op     = hold_op;
  assign push_sample = hold_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_op     <= clear ? OP_CLEAR : OP_SAMPLE;
      hold_sample <= sample;
    end
  end

endmodule

FILE: rtl/mavw_fifo.sv
// ----------------------------------------------------------------------------
// mavw_fifo
// Small first-in first-out queue between the input stage and the datapath.
// ----------------------------------------------------------------------------
module mavw_fifo #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/mavw_back.sv
// ----------------------------------------------------------------------------
// mavw_back
// Datapath: sample ring, running sum, fill count and a restoring divider
// that retires one quotient bit per cycle, with the output register.
// ----------------------------------------------------------------------------
module mavw_back #(
  parameter int MAX_WINDOW  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mavw_pkg::WLEN_BITS-1:0]    cfg_wdata,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  mavw_pkg::op_t                     q_op,
  input  logic signed [SAMPLE_BITS-1:0]     q_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]     mean
);
  import mavw_pkg::*;

  localparam int WW       = $clog2(MAX_WINDOW + 1);
  localparam int SW       = $clog2(MAX_WINDOW);
  localparam int SUM_BITS = SAMPLE_BITS + WW;
  localparam int CW       = $clog2(SUM_BITS);
  localparam logic [SUM_BITS-1:0] POS_MAX =
    SUM_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [SUM_BITS-1:0] NEG_MAX =
    SUM_BITS'(64'd1 << (SAMPLE_BITS - 1));

  state_t state;
  state_t state_next;

  logic [WLEN_BITS-1:0]          window_len;
  logic [WW-1:0]                 eff_w;
  logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SUM_BITS-1:0]    sum;
  logic signed [SUM_BITS-1:0]    sum_next;
  logic [SW-1:0]                 slot;
  logic [SW-1:0]                 slot_next;
  logic [WW-1:0]                 fill;
  logic                          full;
  logic [WW-1:0]                 divisor;
  logic [SUM_BITS-1:0]           mag;

  logic [WW:0]                   rem;
  logic [WW:0]                   rem_shift;
  logic [WW:0]                   rem_step;
  logic [SUM_BITS-1:0]           quo;
  logic [SUM_BITS-1:0]           quo_step;
  logic [SUM_BITS-1:0]           quo_neg;
  logic [WW-1:0]                 dvs;
  logic                          neg;
  logic [CW-1:0]                 cnt;
  logic signed [SAMPLE_BITS-1:0] mean_val;

  logic                          pop;
  logic                          out_load;

  // effective window, clamped to 1..MAX_WINDOW
  always_comb begin
    if (window_len == '0) begin
      eff_w = WW'(1);
    end else if (32'(window_len) > MAX_WINDOW) begin
      eff_w = WW'(MAX_WINDOW);
    end else begin
      eff_w = WW'(window_len);
    end
  end

  assign full      = (fill >= eff_w);
  assign slot_next = (WW'(slot) + WW'(1) == eff_w) ? '0 : slot + SW'(1);
  assign divisor   = full ? eff_w : fill + WW'(1);
  assign sum_next  = sum + SUM_BITS'(x) - (full ? SUM_BITS'(rd_data) : '0);
  assign mag       = sum_next[SUM_BITS-1] ? (~sum_next + SUM_BITS'(1)) : sum_next;

  // one restoring division step
  assign rem_shift = {rem[WW-1:0], quo[SUM_BITS-1]};
  always_comb begin
    if (rem_shift >= {1'b0, dvs}) begin
      rem_step = rem_shift - {1'b0, dvs};
      quo_step = {quo[SUM_BITS-2:0], 1'b1};
    end else begin
      rem_step = rem_shift;
      quo_step = {quo[SUM_BITS-2:0], 1'b0};
    end
  end

  // sign restore and saturation
  assign quo_neg = ~quo + SUM_BITS'(1);
  always_comb begin
    if (!neg && quo > POS_MAX) begin
      mean_val = SAMPLE_BITS'(POS_MAX);
    end else if (neg && quo > NEG_MAX) begin
      mean_val = SAMPLE_BITS'(NEG_MAX);
    end else if (neg) begin
      mean_val = SAMPLE_BITS'(quo_neg);
    end else begin
      mean_val = SAMPLE_BITS'(quo);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = (q_op == OP_CLEAR) ? ST_OUT : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (cnt == CW'(SUM_BITS - 1)) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    q_ready  = (state == ST_IDLE);
    out_load = (state == ST_OUT) && (!out_valid || out_ready);
  end

  assign pop = q_valid && q_ready;

  // ring memory, registered read
  always_ff @(posedge clk) begin
    rd_data <= ring[slot];
    if (state == ST_UPDATE) begin
      ring[slot] <= x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      window_len <= WLEN_RESET;
      sum        <= '0;
      slot       <= '0;
      fill       <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        window_len <= cfg_wdata;
        sum        <= '0;
        slot       <= '0;
        fill       <= '0;
      end else if (pop && q_op == OP_CLEAR) begin
        sum  <= '0;
        slot <= '0;
        fill <= '0;
      end else if (state == ST_UPDATE) begin
        sum  <= sum_next;
        slot <= slot_next;
        if (!full) begin
          fill <= fill + WW'(1);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x   <= q_sample;
      quo <= '0;
      neg <= 1'b0;
    end else if (state == ST_UPDATE) begin
      rem <= '0;
      quo <= mag;
      neg <= sum_next[SUM_BITS-1];
      dvs <= divisor;
      cnt <= '0;
    end else if (state == ST_DIV) begin
      rem <= rem_step;
      quo <= quo_step;
      cnt <= cnt + CW'(1);
    end
    if (out_load) begin
      mean <= mean_val;
    end
  end

  a_fill_in_window: assert property (@(posedge clk) disable iff (rst)
    fill <= eff_w)
    else $error("fill count beyond window");

  a_slot_in_window: assert property (@(posedge clk) disable iff (rst)
    WW'(slot) < eff_w)
    else $error("write slot beyond window");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> dvs != '0)
    else $error("divide by zero");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < {1'b0, dvs})
    else $error("remainder not below divisor");

  a_cfg_empties: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> fill == '0 && sum == '0 && slot == '0)
    else $error("store not emptied by window write");

endmodule
